/* hw/rtl/ira_pkg.sv */
// Package for integer_to_radix_ascii.
// Holds the value width, radix limits, ASCII codes and the digit-to-character function.
// No dependencies.
`timescale 1ns / 1ps

package ira_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(VALUE_WIDTH);
  localparam int CNT_W       = $clog2(VALUE_WIDTH);
  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] DEC_DIGITS  = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 7'h2d;

  typedef logic [RADIX_W-1:0] digit_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input digit_t d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_DIGITS) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_LOWER_A + CHAR_W'(d - DEC_DIGITS);
    end
    return c;
  endfunction

endpackage

/* hw/rtl/ira_if.sv */
// Channel interfaces for integer_to_radix_ascii: input value, result character, radix write.
// Depends on ira_pkg.
`timescale 1ns / 1ps

interface ira_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ira_pkg::VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface ira_out_if;
  logic                         valid;
  logic                         ready;
  logic [ira_pkg::CHAR_W-1:0]   character;
  logic                         last_char;
  logic                         empty_res;

  modport source (output valid, output character, output last_char, output empty_res,
                  input ready);
  modport sink   (input valid, input character, input last_char, input empty_res,
                  output ready);
endinterface

interface ira_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [ira_pkg::RADIX_W-1:0] radix;

  modport source (output valid, output radix, input ready);
  modport sink   (input valid, input radix, output ready);
endinterface

/* hw/rtl/integer_to_radix_ascii.sv */
// Top level: converts a signed integer to ASCII text in a configured base (2..36).
// Depends on ira_pkg, ira_if.sv interfaces and ira_div.
//
// Usage:
//   in_ch  : one transaction per signed VALUE_WIDTH-bit value.
//   out_ch : one transaction per character, most significant first; '-' leads a
//            negative value, last_char marks the final one. With a radix outside
//            2..36 a single transaction with empty_res = 1, character 0 is given.
//   cfg_ch : writes the 6-bit radix (reset 10); always ready, write only while idle.
// Operation:
//   each digit comes from the bit-serial divider (one quotient bit per cycle,
//   VALUE_WIDTH bits), then each character passes through the digit store read
//   and the output register, after a leading '-' for a negative value; one value
//   is worked at a time.
// Reset (rst_n low, synchronous) empties the output register and returns to idle.
// A stalled receiver holds the output register; the next value is accepted as
// soon as the last character sits in the output register.
`timescale 1ns / 1ps

module integer_to_radix_ascii (
  input logic      clk,
  input logic      rst_n,
  ira_in_if.sink   in_ch,
  ira_out_if.source out_ch,
  ira_cfg_if.sink  cfg_ch
);

  localparam int W = ira_pkg::VALUE_WIDTH;
  localparam int D = ira_pkg::VALUE_WIDTH;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_SIGN  = 6'b000100,
    S_RD    = 6'b001000,
    S_OUT   = 6'b010000,
    S_EMPTY = 6'b100000
  } state_t;

  state_t                         state_r, state_nxt;
  ira_pkg::digit_t                radix_r;
  logic                           neg_r, neg_nxt;
  logic [ira_pkg::IDX_W-1:0]      cnt_r, cnt_nxt;
  logic [ira_pkg::IDX_W-1:0]      ptr_r, ptr_nxt;
  ira_pkg::digit_t                store [D];
  ira_pkg::digit_t                rd_data_r;

  logic                           out_valid_r;
  logic [ira_pkg::CHAR_W-1:0]     out_char_r;
  logic                           out_last_r;
  logic                           out_empty_r;

  logic                           load;
  logic [ira_pkg::CHAR_W-1:0]     load_char;
  logic                           load_last;
  logic                           load_empty;
  logic                           out_free;
  logic                           in_acc;
  logic                           radix_ok;
  logic [W-1:0]                   mag;
  logic                           st_wr;

  ira_pkg::div_ctl_t              div_ctl;
  ira_pkg::div_stat_t             div_stat;
  logic [W-1:0]                   div_dividend;
  logic [W-1:0]                   quotient;
  ira_pkg::digit_t                remainder;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign radix_ok     = (radix_r >= ira_pkg::RADIX_MIN) && (radix_r <= ira_pkg::RADIX_MAX);
  assign mag          = in_ch.value[W-1] ? ($unsigned(~in_ch.value) + W'(1))
                                         : $unsigned(in_ch.value);

  ira_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .dividend  (div_dividend),
    .divisor   (radix_r),
    .stat      (div_stat),
    .quotient  (quotient),
    .remainder (remainder)
  );

  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    div_ctl.start = 1'b0;
    div_dividend  = quotient;
    st_wr         = 1'b0;
    load          = 1'b0;
    load_char     = ira_pkg::digit_char(rd_data_r);
    load_last     = 1'b0;
    load_empty    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (radix_ok) begin
            neg_nxt       = in_ch.value[W-1];
            cnt_nxt       = '0;
            div_ctl.start = 1'b1;
            div_dividend  = mag;
            state_nxt     = S_DIV;
          end else begin
            state_nxt = S_EMPTY;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          st_wr = 1'b1;
          if ((quotient != '0) && (cnt_r != ira_pkg::IDX_W'(D - 1))) begin
            cnt_nxt       = cnt_r + 1'b1;
            div_ctl.start = 1'b1;
          end else begin
            ptr_nxt   = cnt_r;
            state_nxt = neg_r ? S_SIGN : S_RD;
          end
        end
      end
      S_SIGN: begin
        if (out_free) begin
          load      = 1'b1;
          load_char = ira_pkg::CHAR_MINUS;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          load      = 1'b1;
          load_last = (ptr_r == '0);
          if (ptr_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt   = ptr_r - 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          load       = 1'b1;
          load_char  = '0;
          load_last  = 1'b1;
          load_empty = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      radix_r     <= ira_pkg::RADIX_RESET;
      neg_r       <= 1'b0;
      cnt_r       <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      neg_r   <= neg_nxt;
      cnt_r   <= cnt_nxt;
      ptr_r   <= ptr_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        radix_r <= cfg_ch.radix;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char_r  <= load_char;
      out_last_r  <= load_last;
      out_empty_r <= load_empty;
    end
  end

  // digit store, least significant digit first
  always_ff @(posedge clk) begin
    if (st_wr) begin
      store[cnt_r] <= remainder;
    end
    rd_data_r <= store[ptr_r];
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last_char = out_last_r;
  assign out_ch.empty_res = out_empty_r;

  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_empty_r |-> out_last_r && (out_char_r == '0))
    else $error("empty result malformed");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("accepted value did not start work");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> rd_data_r < radix_r)
    else $error("stored digit not below radix");

endmodule

/* hw/rtl/ira_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle by a 6-bit radix.
// Depends on ira_pkg.
`timescale 1ns / 1ps

module ira_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ira_pkg::div_ctl_t                  ctl,
  input  logic [ira_pkg::VALUE_WIDTH-1:0]    dividend,
  input  ira_pkg::digit_t                    divisor,
  output ira_pkg::div_stat_t                 stat,
  output logic [ira_pkg::VALUE_WIDTH-1:0]    quotient,
  output ira_pkg::digit_t                    remainder
);

  localparam int W = ira_pkg::VALUE_WIDTH;

  logic [W-1:0]                  quo_r;
  ira_pkg::digit_t               rem_r;
  logic [ira_pkg::CNT_W-1:0]     cnt_r;
  logic                          busy_r;
  logic                          done_r;

  logic [ira_pkg::RADIX_W:0]     rem_sh;
  logic                          ge;
  ira_pkg::digit_t               rem_nxt;

  assign rem_sh  = {rem_r, quo_r[W-1]};
  assign ge      = rem_sh >= {1'b0, divisor};
  assign rem_nxt = ge ? ira_pkg::RADIX_W'(rem_sh - {1'b0, divisor})
                      : rem_sh[ira_pkg::RADIX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == ira_pkg::CNT_W'(W - 1));
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ira_pkg::CNT_W'(W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> busy_r && !done_r)
    else $error("divider did not start");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && (divisor >= ira_pkg::RADIX_MIN) |-> rem_r < divisor)
    else $error("remainder not below divisor");

endmodule

/* bench/tb_integer_to_radix_ascii.sv */
// Self-checking testbench for integer_to_radix_ascii: directed table, then random radix phases.
// Each accepted value queues its expected characters (table text or predictor), matched in order.
// Depends on ira_pkg, the ira_if.sv interfaces and the integer_to_radix_ascii RTL.
`timescale 1ns / 1ps

module tb_integer_to_radix_ascii;
  import ira_pkg::*;

  localparam int DIRECTED_ROWS = 24;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 31;
  localparam int HOLD_CYCLES   = 600;
  localparam int TAIL_CYCLES   = 1200;
  localparam int IDLE_LIMIT    = 20000;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last_char;
    logic              empty_res;
  } char_result_t;

  typedef struct packed {
    logic [RADIX_W-1:0]     radix;
    logic [VALUE_WIDTH-1:0] value;
  } probe_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ira_in_if  in_ch ();
  ira_out_if out_ch ();
  ira_cfg_if cfg_ch ();

  integer_to_radix_ascii u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  char_result_t       pending_chars[$];
  logic [RADIX_W-1:0] radix_setting = RADIX_RESET;
  int                 fail_count = 0;
  int                 idle_cycles = 0;
  bit                 calm = 1'b0;
  bit                 receiver_hold = 1'b0;

  // "*" means the row is checked against the predictor
  probe_t directed_probes [DIRECTED_ROWS] = '{
    '{6'd10, 32'h0000_0000}, '{6'd10, 32'h0000_0001}, '{6'd10, 32'hffff_ffff},
    '{6'd10, 32'h7fff_ffff}, '{6'd10, 32'h8000_0000}, '{6'd10, 32'd12345},
    '{6'd10, 32'hffff_fc75}, '{6'd2,  32'h7fff_ffff}, '{6'd2,  32'h8000_0000},
    '{6'd2,  32'h0000_0005}, '{6'd16, 32'h8000_0000}, '{6'd16, 32'hdead_beef},
    '{6'd16, 32'h7fff_ffff}, '{6'd16, 32'h0000_abcd}, '{6'd36, 32'd35},
    '{6'd36, 32'hffff_ffdc}, '{6'd36, 32'h7fff_ffff}, '{6'd36, 32'h8000_0000},
    '{6'd0,  32'h0000_0005}, '{6'd1,  32'hffff_ffff}, '{6'd37, 32'h0000_0000},
    '{6'd63, 32'h7fff_ffff}, '{6'd3,  32'h5555_5555}, '{6'd8,  32'hffff_ff80}
  };

  string directed_text [DIRECTED_ROWS] = '{
    "0", "1", "-1", "2147483647", "-2147483648", "*", "*",
    "1111111111111111111111111111111",
    "-10000000000000000000000000000000",
    "101", "-80000000", "-21524111", "7fffffff", "abcd", "z", "-10", "*", "*",
    "", "", "", "", "*", "-200"
  };

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= 40) $display("ERROR: %s", what);
  endtask

  // expected characters of one value in the current radix, most significant first
  function automatic void predict_text(input logic [VALUE_WIDTH-1:0] v);
    digit_t            digs [VALUE_WIDTH];
    logic [VALUE_WIDTH-1:0] mag;
    logic [CHAR_W-1:0] ch;
    logic              neg;
    int                n;
    int                total;
    if (radix_setting < RADIX_MIN || radix_setting > RADIX_MAX) begin
      pending_chars.push_back('{'0, 1'b1, 1'b1});
      return;
    end
    neg = v[VALUE_WIDTH-1];
    mag = neg ? (~v + 1'b1) : v;
    n = 0;
    do begin
      digs[n] = digit_t'(mag % radix_setting);
      mag = mag / radix_setting;
      n++;
    end while (mag != 0 && n < VALUE_WIDTH);
    total = n + (neg ? 1 : 0);
    if (neg) pending_chars.push_back('{CHAR_MINUS, total == 1, 1'b0});
    for (int i = n - 1; i >= 0; i--) begin
      if (digs[i] < DEC_DIGITS) ch = CHAR_ZERO + CHAR_W'(digs[i]);
      else ch = CHAR_LOWER_A + CHAR_W'(digs[i] - DEC_DIGITS);
      pending_chars.push_back('{ch, i == 0, 1'b0});
    end
  endfunction

  function automatic void push_text(input string s);
    if (s.len() == 0) begin
      pending_chars.push_back('{'0, 1'b1, 1'b1});
      return;
    end
    for (int i = 0; i < s.len(); i++) begin
      pending_chars.push_back('{CHAR_W'(s[i]), i == s.len() - 1, 1'b0});
    end
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    logic [VALUE_WIDTH-1:0] v;
    longint                 p;
    int                     k;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom();
      2: v = $urandom_range(0, 1000);
      3: begin
        p = 1;
        k = $urandom_range(1, 31);
        if (radix_setting >= RADIX_MIN) begin
          for (int j = 0; j < k; j++) begin
            if (p * radix_setting < 64'h8000_0000) p = p * radix_setting;
          end
        end
        v = VALUE_WIDTH'(p + $urandom_range(0, 2) - 1);
      end
      4: begin
        case ($urandom_range(0, 5))
          0: v = 32'h0000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h8000_0000;
          3: v = 32'hffff_ffff;
          4: v = 32'h0000_0001;
          default: v = 32'h8000_0001;
        endcase
        return v;
      end
      default: v = $urandom() >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  function automatic logic [RADIX_W-1:0] pick_radix(input int phase);
    case (phase)
      0: return 6'd2;
      1: return 6'd36;
      2: return RADIX_W'($urandom_range(37, 63));
      3: return RADIX_W'($urandom_range(2, 36));
      default: begin
        if ($urandom_range(0, 5) == 0) begin
          if ($urandom_range(0, 1)) return RADIX_W'($urandom_range(0, 1));
          return RADIX_W'($urandom_range(37, 63));
        end
        return RADIX_W'($urandom_range(2, 36));
      end
    endcase
  endfunction

  task automatic send_value(input logic [VALUE_WIDTH-1:0] v, input string text);
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (text == "*") predict_text(v);
    else push_text(text);
  endtask

  task automatic pause_sender(input int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    cfg_ch.valid <= 1'b1;
    cfg_ch.radix <= r;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    radix_setting = r;
  endtask

  initial begin
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.radix <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed_probes[i].radix != radix_setting) begin
        settle_block();
        write_radix(directed_probes[i].radix);
      end
      if ($urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 5));
      send_value(directed_probes[i].value, directed_text[i]);
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle_block();
      if (phase == RANDOM_PHASES - 1) calm = 1'b1;
      write_radix(pick_radix(phase));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 3 && n == 3) receiver_hold = 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 5));
        send_value(pick_value(), "*");
      end
    end

    settle_block();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("integer_to_radix_ascii verification clean");
    end else begin
      $display("integer_to_radix_ascii verification failed");
    end
    $finish;
  end

  // result receiver with random stalls and one long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (receiver_hold) begin
        receiver_hold = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    char_result_t got;
    char_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.character, out_ch.last_char, out_ch.empty_res};
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("char %h last %b empty %b with nothing pending",
                                  got.character, got.last_char, got.empty_res));
      end else begin
        want = pending_chars.pop_front();
        if (got.character !== want.character || got.last_char !== want.last_char ||
            got.empty_res !== want.empty_res) begin
          report_mismatch($sformatf("char %h/%h last %b/%b empty %b/%b (got/expected)",
                                    got.character, want.character, got.last_char,
                                    want.last_char, got.empty_res, want.empty_res));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles, %0d results pending",
               idle_cycles, pending_chars.size());
      $display("integer_to_radix_ascii verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

/* sim.f */
hw/rtl/ira_pkg.sv
hw/rtl/ira_if.sv
hw/rtl/ira_div.sv
hw/rtl/integer_to_radix_ascii.sv
bench/tb_integer_to_radix_ascii.sv
